FILE: hdl/bsram_pkg.sv
// Shared types and constants for the battery save-RAM window block.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package bsram_pkg;

  // Field widths of the request and result items
  localparam int OP_W        = 3;
  localparam int BUS_ADDR_W  = 24;
  localparam int VALUE_W     = 16;
  localparam int FRAMES_W    = 8;
  localparam int THRESH_W    = 16;
  localparam int USED_W      = 17;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Operation codes carried in in_tuser
  localparam logic [OP_W-1:0] OP_RD_BYTE = 3'd0;
  localparam logic [OP_W-1:0] OP_RD_WORD = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_BYTE = 3'd2;
  localparam logic [OP_W-1:0] OP_WR_WORD = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WIN_START   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN_LAST    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAVE_FRAMES = 2'd2;

  // Reset values of the configuration registers
  localparam logic [BUS_ADDR_W-1:0] WIN_START_RST   = 24'h200000;
  localparam logic [BUS_ADDR_W-1:0] WIN_LAST_RST    = 24'h20FFFF;
  localparam logic [THRESH_W-1:0]   SAVE_FRAMES_RST = 16'd62;

  // Data constants
  localparam logic [7:0]         BYTE_ERASED = 8'hFF;
  localparam logic [VALUE_W-1:0] WORD_ERASED = 16'hFFFF;
  localparam logic [THRESH_W-1:0] FSUM_MAX   = 16'hFFFF;
  localparam logic [USED_W-1:0]  USED_SAT    = 17'h1FFFF;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_ACCESS = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_SIZE   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [BUS_ADDR_W-1:0] win_start;
    logic [BUS_ADDR_W-1:0] win_last;
    logic [THRESH_W-1:0]   save_frames;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]       operation;
    logic [BUS_ADDR_W-1:0] bus_address;
    logic [VALUE_W-1:0]    write_value;
    logic [FRAMES_W-1:0]   frame_count;
    logic                  force_save;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               is_dirty;
    logic               save_request;
    logic [USED_W-1:0]  used_bytes;
  } result_t;

  // Enables of the two byte banks: index 0 even bank, index 1 odd bank
  typedef struct packed {
    logic [1:0] en;
    logic [1:0] we;
  } bank_ctl_t;

endpackage

FILE: hdl/bsram_banks.sv
// Save memory split into an even-offset and an odd-offset byte bank.
// Each bank is a single-port synchronous RAM with registered read data.
// Depends on bsram_pkg.
`timescale 1ns / 1ps

module bsram_banks import bsram_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                           clk,
  input  bank_ctl_t                      ctl,
  input  logic [$clog2(MEM_BYTES)-2:0]   even_addr,
  input  logic [$clog2(MEM_BYTES)-2:0]   odd_addr,
  input  logic [7:0]                     even_wdata,
  input  logic [7:0]                     odd_wdata,
  output logic [7:0]                     even_rdata,
  output logic [7:0]                     odd_rdata
);

  localparam int ROWS = MEM_BYTES / 2;

  logic [7:0] mem_even [ROWS];
  logic [7:0] mem_odd  [ROWS];

  // even bank: read data holds while the bank is not enabled
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      if (ctl.we[0]) begin
        mem_even[even_addr] <= even_wdata;
      end else begin
        even_rdata <= mem_even[even_addr];
      end
    end
  end

  // odd bank
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      if (ctl.we[1]) begin
        mem_odd[odd_addr] <= odd_wdata;
      end else begin
        odd_rdata <= mem_odd[odd_addr];
      end
    end
  end

endmodule

FILE: hdl/bsram_ctrl.sv
// Sequencer of the save-RAM block: window decode, read-modify-write of
// the banks, dirty/frame bookkeeping, the used-size scan and the post-reset clear.
// Depends on bsram_pkg; drives bsram_banks.
`timescale 1ns / 1ps

module bsram_ctrl import bsram_pkg::*; #(
  parameter int MEM_BYTES = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  item_t                          in_item,
  output logic                           res_valid,
  input  logic                           res_take,
  output result_t                        res,
  output bank_ctl_t                      bank_ctl,
  output logic [$clog2(MEM_BYTES)-2:0]   even_addr,
  output logic [$clog2(MEM_BYTES)-2:0]   odd_addr,
  output logic [7:0]                     even_wdata,
  output logic [7:0]                     odd_wdata,
  input  logic [7:0]                     even_rdata,
  input  logic [7:0]                     odd_rdata
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = AW - 1;
  localparam int PW = AW + 1;
  localparam int XW = PW + USED_W;

  state_t                state_r, state_nxt;
  logic [RW-1:0]         clr_idx_r, clr_idx_nxt;
  logic [OP_W-1:0]       op_r;
  logic [AW-1:0]         a_r;
  logic                  hit_r;
  logic [VALUE_W-1:0]    wval_r;
  logic [FRAMES_W-1:0]   frames_r;
  logic                  force_r;
  logic                  dirty_r, dirty_nxt;
  logic [THRESH_W-1:0]   fsum_r, fsum_nxt;
  logic [AW-1:0]         hwm_r, hwm_nxt;
  logic                  hwm_vld_r, hwm_vld_nxt;
  logic [RW-1:0]         scan_idx_r, scan_idx_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [RW-1:0]         chk_idx_r;
  logic [AW-1:0]         last_r, last_nxt;
  logic                  none_r, none_nxt;

  // Window decode of the incoming request
  logic [BUS_ADDR_W-1:0] off_w;
  logic                  hit_in;
  logic [AW-1:0]         a_in;

  assign off_w  = in_item.bus_address - cfg.win_start;
  assign hit_in = (in_item.bus_address >= cfg.win_start) &&
                  (in_item.bus_address <= cfg.win_last);
  assign a_in   = hit_in ? off_w[AW-1:0] : '0;
  assign in_ready = (state_r == ST_IDLE);

  // Even-bank row of the byte pair at a: next row when a is odd
  function automatic logic [RW-1:0] even_row(input logic [AW-1:0] a);
    logic [RW-1:0] row;
    row = a[AW-1:1];
    return a[0] ? RW'(row + 1'b1) : row;
  endfunction

  // Access stage: bytes a and a+1 of the current request
  logic [7:0]    byte_a, byte_b, new_a, new_b;
  logic [AW-1:0] b_off;
  logic          is_word, is_wr, chg, do_wr;

  assign byte_a  = a_r[0] ? odd_rdata  : even_rdata;
  assign byte_b  = a_r[0] ? even_rdata : odd_rdata;
  assign b_off   = AW'(a_r + 1'b1);
  assign is_word = (op_r == OP_WR_WORD);
  assign is_wr   = (op_r == OP_WR_BYTE) || is_word;
  assign new_a   = is_word ? wval_r[15:8] : wval_r[7:0];
  assign new_b   = wval_r[7:0];
  assign chg     = (byte_a != new_a) || (is_word && (byte_b != new_b));

  // Frame accumulation with saturation
  logic [THRESH_W:0]   fsum_add;
  logic [THRESH_W-1:0] fsum_sat;
  logic                tick, go;

  assign fsum_add = {1'b0, fsum_r} + {{(THRESH_W+1-FRAMES_W){1'b0}}, frames_r};
  assign fsum_sat = fsum_add[THRESH_W] ? FSUM_MAX : fsum_add[THRESH_W-1:0];
  assign tick     = (op_r == OP_TICK);
  assign go       = tick && dirty_r && (force_r || (fsum_sat >= cfg.save_frames));

  // Highest offset ever written with a non-erased byte
  logic          cand_a, cand_b, vld1;
  logic [AW-1:0] h1, h2;

  assign cand_a = new_a != BYTE_ERASED;
  assign cand_b = is_word && (new_b != BYTE_ERASED);
  assign h1     = (cand_a && (!hwm_vld_r || (a_r > hwm_r))) ? a_r : hwm_r;
  assign vld1   = hwm_vld_r || cand_a;
  assign h2     = (cand_b && (!vld1 || (b_off > h1))) ? b_off : h1;

  // Read data of the access stage
  logic [VALUE_W-1:0] rd_val;
  always_comb begin
    rd_val = '0;
    if (op_r == OP_RD_BYTE) begin
      rd_val = hit_r ? {8'h00, byte_a} : {8'h00, BYTE_ERASED};
    end else if (op_r == OP_RD_WORD) begin
      rd_val = hit_r ? {byte_a, byte_b} : WORD_ERASED;
    end
  end

  // Power-of-two used size from the last non-erased offset, saturated at USED_SAT
  logic [AW-1:0]   smear;
  logic [PW-1:0]   pow2;
  logic [XW-1:0]   pow2_x;
  logic [USED_W-1:0] used_sz;

  always_comb begin
    smear = last_r;
    for (int s = 1; s < AW; s = s * 2) begin
      smear = smear | (smear >> s);
    end
    pow2   = {1'b0, smear} + PW'(1);
    pow2_x = XW'(pow2);
    if (none_r) begin
      used_sz = '0;
    end else if (pow2_x > XW'(USED_SAT)) begin
      used_sz = USED_SAT;
    end else begin
      used_sz = pow2_x[USED_W-1:0];
    end
  end

  // Scan check: highest non-erased byte of the row read last cycle
  logic          scan_hit;
  logic [AW-1:0] scan_last;
  always_comb begin
    scan_hit  = chk_v_r && ((odd_rdata != BYTE_ERASED) || (even_rdata != BYTE_ERASED));
    scan_last = (odd_rdata != BYTE_ERASED) ? {chk_idx_r, 1'b1} : {chk_idx_r, 1'b0};
  end

  // Sequencer
  logic go_scan;
  assign go_scan = go && hwm_vld_r;

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    dirty_nxt    = dirty_r;
    fsum_nxt     = fsum_r;
    hwm_nxt      = hwm_r;
    hwm_vld_nxt  = hwm_vld_r;
    scan_idx_nxt = scan_idx_r;
    chk_v_nxt    = 1'b0;
    last_nxt     = last_r;
    none_nxt     = none_r;
    do_wr        = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    bank_ctl     = '0;
    even_addr    = even_row(a_r);
    odd_addr     = a_r[AW-1:1];
    even_wdata   = a_r[0] ? new_b : new_a;
    odd_wdata    = a_r[0] ? new_a : new_b;

    case (state_r)
      ST_CLEAR: begin
        bank_ctl.en = 2'b11;
        bank_ctl.we = 2'b11;
        even_addr   = clr_idx_r;
        odd_addr    = clr_idx_r;
        even_wdata  = BYTE_ERASED;
        odd_wdata   = BYTE_ERASED;
        clr_idx_nxt = RW'(clr_idx_r + 1'b1);
        if (&clr_idx_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        even_addr   = even_row(a_in);
        odd_addr    = a_in[AW-1:1];
        bank_ctl.en = {2{in_valid}};
        if (in_valid) begin
          state_nxt = ST_ACCESS;
        end
      end

      ST_ACCESS: begin
        if (go_scan) begin
          // Memory holds data: find the used size before answering
          dirty_nxt    = 1'b0;
          fsum_nxt     = '0;
          scan_idx_nxt = hwm_r[AW-1:1];
          state_nxt    = ST_SCAN;
        end else begin
          res_valid         = 1'b1;
          res.read_value    = rd_val;
          res.is_dirty      = (go ? 1'b0 : dirty_r) || (is_wr && hit_r && chg);
          res.save_request  = go;
          res.used_bytes    = '0;
          if (res_take) begin
            state_nxt = ST_IDLE;
            if (is_wr && hit_r && chg) begin
              do_wr       = 1'b1;
              dirty_nxt   = 1'b1;
              hwm_nxt     = h2;
              hwm_vld_nxt = vld1 || cand_b;
            end else if (go) begin
              dirty_nxt = 1'b0;
              fsum_nxt  = '0;
            end else if (tick && dirty_r) begin
              fsum_nxt = fsum_sat;
            end
          end
        end
        if (do_wr) begin
          bank_ctl.en = is_word ? 2'b11 : {a_r[0], ~a_r[0]};
          bank_ctl.we = bank_ctl.en;
        end
      end

      ST_SCAN: begin
        bank_ctl.en  = 2'b11;
        even_addr    = scan_idx_r;
        odd_addr     = scan_idx_r;
        scan_idx_nxt = RW'(scan_idx_r - 1'b1);
        chk_v_nxt    = 1'b1;
        if (scan_hit) begin
          last_nxt  = scan_last;
          none_nxt  = 1'b0;
          hwm_nxt   = scan_last;
          state_nxt = ST_SIZE;
        end else if (chk_v_r && (chk_idx_r == '0)) begin
          none_nxt    = 1'b1;
          hwm_vld_nxt = 1'b0;
          state_nxt   = ST_SIZE;
        end
      end

      ST_SIZE: begin
        res_valid        = 1'b1;
        res.save_request = 1'b1;
        res.used_bytes   = used_sz;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      dirty_r   <= 1'b0;
      fsum_r    <= '0;
      hwm_vld_r <= 1'b0;
      chk_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      dirty_r   <= dirty_nxt;
      fsum_r    <= fsum_nxt;
      hwm_vld_r <= hwm_vld_nxt;
      chk_v_r   <= chk_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hwm_r      <= hwm_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= scan_idx_r;
    last_r     <= last_nxt;
    none_r     <= none_nxt;
    if (in_valid && in_ready) begin
      op_r     <= in_item.operation;
      a_r      <= a_in;
      hit_r    <= hit_in;
      wval_r   <= in_item.write_value;
      frames_r <= in_item.frame_count;
      force_r  <= in_item.force_save;
    end
  end

endmodule

FILE: hdl/battery_sram_window_with_autosave.sv
// Top level of the battery save-RAM window with autosave: configuration
// registers, result register and the stream ports.
// Depends on bsram_pkg, bsram_ctrl and bsram_banks.
//
//  port group  | dir | contents
//  ------------+-----+----------------------------------------------------
//  in_*        | in  | bus access or frame tick request, kind in in_tuser
//  out_*       | out | one result per request
//  cfg_*       | in  | register write: 0 window start, 1 window end,
//              |     | 2 autosave frame threshold
//
// Each request passes through decode and bank read, then modify/write back
// and result. A save that finds data scans the two banks one row (two bytes)
// a cycle, downwards from the highest row that can still hold non-0xFF data.
// After reset a clearing pass writes 0xFF into every row, with in_tready
// low. A held result in the output register stalls the next completion,
// not the next acceptance.
`timescale 1ns / 1ps

module battery_sram_window_with_autosave import bsram_pkg::*; #(
  parameter int MEM_BYTES = 65536  // power of two, 256 to 1048576
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // request stream
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // [23:0] bus_address, [39:24] write_value, [47:40] frame_count,
  // [48] force_save, [55:49] zero
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // [2:0] operation
  input  logic [OP_W-1:0]         in_tuser,
  // result stream
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [15:0] read_value, [16] is_dirty, [17] save_request,
  // [34:18] used_bytes, [39:35] zero
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  // register writes
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int RW = $clog2(MEM_BYTES) - 1;

  cfg_t      cfg_r;
  item_t     item;
  result_t   res, out_res_r;
  logic      res_valid, res_take, out_valid_r;
  bank_ctl_t bank_ctl;
  logic [RW-1:0] even_addr, odd_addr;
  logic [7:0]    even_wdata, odd_wdata, even_rdata, odd_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_start   <= WIN_START_RST;
      cfg_r.win_last    <= WIN_LAST_RST;
      cfg_r.save_frames <= SAVE_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIN_START:   cfg_r.win_start   <= cfg_wdata;
        REG_WIN_LAST:    cfg_r.win_last    <= cfg_wdata;
        REG_SAVE_FRAMES: cfg_r.save_frames <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Request unpacking
  assign item.operation   = in_tuser;
  assign item.bus_address = in_tdata[23:0];
  assign item.write_value = in_tdata[39:24];
  assign item.frame_count = in_tdata[47:40];
  assign item.force_save  = in_tdata[48];

  // Output register: loads when empty or being drained
  assign res_take = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.used_bytes, out_res_r.save_request,
                       out_res_r.is_dirty, out_res_r.read_value};

  bsram_ctrl #(
    .MEM_BYTES (MEM_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (item),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .bank_ctl   (bank_ctl),
    .even_addr  (even_addr),
    .odd_addr   (odd_addr),
    .even_wdata (even_wdata),
    .odd_wdata  (odd_wdata),
    .even_rdata (even_rdata),
    .odd_rdata  (odd_rdata)
  );

  bsram_banks #(
    .MEM_BYTES (MEM_BYTES)
  ) u_banks (
    .clk        (clk),
    .ctl        (bank_ctl),
    .even_addr  (even_addr),
    .odd_addr   (odd_addr),
    .even_wdata (even_wdata),
    .odd_wdata  (odd_wdata),
    .even_rdata (even_rdata),
    .odd_rdata  (odd_rdata)
  );

endmodule
